// ===== hw/rtl/cbwf_pkg.sv =====
// cbwf_pkg: shared types and constants for the clamped border window filter
// no dependencies; imported by every module of the block except cbwf_line_ram
`timescale 1ns / 1ps

package cbwf_pkg;

  // item modes
  localparam logic [1:0] MODE_COEF  = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_W        = 11;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int MAX_HEIGHT   = 1024;
  localparam int ROW_W        = 11;   // input row, may reach the height itself
  localparam int OROW_W       = 10;   // output row, always below the height

  localparam int PW         = 24;     // 8 bit sample times Q1.14 coefficient
  localparam int FRAC_BITS  = 14;
  localparam int ROUND_HALF = 8192;
  localparam int SAT_MAX    = 32767;
  localparam int SAT_MIN    = -32768;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         coef_channel;
    logic [2:0]         coef_col;
    logic [2:0]         coef_row;
    logic signed [15:0] coef_value;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] red_out;
    logic signed [15:0] green_out;
    logic signed [15:0] blue_out;
    logic               frame_last;
  } out_word_t;

  // what the window front end decides for the word being accepted
  typedef struct packed {
    logic emit;
    logic last;
  } issue_t;

  // stage load enables handed to each lane
  typedef struct packed {
    logic mul;
    logic rsum;
    logic tsum;
    logic fin;
  } lane_en_t;

  typedef struct packed {
    logic               we;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
  } coef_wr_t;

endpackage

// ===== hw/rtl/cbwf_line_ram.sv =====
// cbwf_line_ram: one bank of line buffer, one write and one registered read port
// read returns the word written at the same edge; uses no package items
`timescale 1ns / 1ps

module cbwf_line_ram #(
  parameter int DEPTH = 205,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/cbwf_lane.sv =====
// cbwf_lane: multiply-accumulate lane for one colour channel
// holds the channel kernel, products, row sums, total and rounded result; uses cbwf_pkg
`timescale 1ns / 1ps

module cbwf_lane #(
  parameter int KSIZE = 5
) (
  input  logic                               clk,
  input  cbwf_pkg::lane_en_t                 en,
  input  cbwf_pkg::coef_wr_t                 coef_wr,
  input  logic [KSIZE-1:0][KSIZE-1:0][7:0]   win,
  output logic signed [15:0]                 result
);

  import cbwf_pkg::*;

  localparam int RW = PW + $clog2(KSIZE);
  localparam int TW = RW + $clog2(KSIZE);
  localparam int VW = (TW + 1 > 18) ? TW + 1 : 18;
  localparam int QW = VW - FRAC_BITS;

  logic signed [15:0]   coef    [KSIZE][KSIZE];
  logic signed [PW-1:0] prod    [KSIZE][KSIZE];
  logic signed [RW-1:0] rowsum  [KSIZE];
  logic signed [RW-1:0] rowsum_next [KSIZE];
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] total_next;
  logic signed [15:0]   result_next;

  always_comb begin
    for (int m = 0; m < KSIZE; m++) begin
      rowsum_next[m] = '0;
      for (int l = 0; l < KSIZE; l++) begin
        rowsum_next[m] = rowsum_next[m] + RW'(prod[m][l]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int m = 0; m < KSIZE; m++) begin
      total_next = total_next + TW'(rowsum[m]);
    end
  end

  // round half up, arithmetic shift, saturate to 16 bit
  always_comb begin
    logic signed [VW-1:0] v;
    logic signed [QW-1:0] q;
    v = VW'(total) + VW'(ROUND_HALF);
    q = QW'(v >>> FRAC_BITS);
    if (q > QW'(SAT_MAX)) begin
      result_next = 16'sh7FFF;
    end else if (q < QW'(SAT_MIN)) begin
      result_next = -16'sh8000;
    end else begin
      result_next = 16'(q);
    end
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < KSIZE; m++) begin
      for (int l = 0; l < KSIZE; l++) begin
        if (coef_wr.we && 32'(coef_wr.row) == m && 32'(coef_wr.col) == l) begin
          coef[m][l] <= coef_wr.value;
        end
        if (en.mul) begin
          prod[m][l] <= PW'($signed({1'b0, win[m][l]}) * coef[m][l]);
        end
      end
      if (en.rsum) begin
        rowsum[m] <= rowsum_next[m];
      end
    end
    if (en.tsum) begin
      total <= total_next;
    end
    if (en.fin) begin
      result <= result_next;
    end
  end

endmodule

// ===== hw/rtl/cbwf_window.sv =====
// cbwf_window: frame counters, line buffer banks and clamped window gathering
// banks by row slot and by column modulo the kernel size; uses cbwf_pkg, cbwf_line_ram
`timescale 1ns / 1ps

module cbwf_window #(
  parameter int KSIZE     = 5,
  parameter int MAX_WIDTH = 1024,
  parameter int CHANNELS  = 3
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             cfg_we,
  input  logic                                             cfg_index,
  input  logic [cbwf_pkg::CFG_W-1:0]                       cfg_data,
  input  logic                                             accept,
  input  cbwf_pkg::in_word_t                               in_word,
  input  logic                                             win_load,
  output cbwf_pkg::issue_t                                 issue,
  output logic [CHANNELS-1:0][KSIZE-1:0][KSIZE-1:0][7:0]   win
);

  import cbwf_pkg::*;

  localparam int R     = (KSIZE - 1) / 2;
  localparam int NROWS = KSIZE + 1;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (CW > ROW_W) ? CW : ROW_W;
  localparam int SW    = EW + 2;
  localparam int DEPTH = (MAX_WIDTH + KSIZE - 1) / KSIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = (KSIZE > 1) ? $clog2(KSIZE) : 1;
  localparam int SLW   = $clog2(NROWS);
  localparam int PIX_W = 8 * CHANNELS;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic [CW-1:0]     in_col,  in_col_next,  out_col;
  logic [AW-1:0]     in_q,    in_q_next,    out_q;
  logic [BW-1:0]     in_r,    in_r_next,    out_r;
  logic [ROW_W-1:0]  in_row,  in_row_next;
  logic [OROW_W-1:0] out_row;
  logic [SLW-1:0]    in_slot, in_slot_next, out_slot;

  logic [CW-1:0]    eff_w, wm1, col_inc, ocol_inc, cx;
  logic [ROW_W-1:0] eff_h, hm1, cy, orow_inc;
  logic [CW:0]      cx_raw;
  logic [ROW_W-1:0] cy_raw;
  logic             px, data_ready, wrap_col;

  logic [AW-1:0]    raddr     [KSIZE];
  logic [BW-1:0]    bank_c    [KSIZE];
  logic [SLW-1:0]   slot_c    [KSIZE];
  logic [BW-1:0]    bank_sel  [KSIZE];
  logic [SLW-1:0]   slot_sel  [KSIZE];
  logic [PIX_W-1:0] rd        [NROWS][KSIZE];
  logic [2:0][7:0]  all_pix;
  logic [PIX_W-1:0] pix;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = ROW_W'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(frame_height);
    end
    wm1 = eff_w - 1'b1;
    hm1 = eff_h - 1'b1;
  end

  // input position after this word's pixel is stored
  always_comb begin
    px           = accept && in_word.mode == MODE_PIXEL && in_row < eff_h;
    col_inc      = in_col + 1'b1;
    in_col_next  = in_col;
    in_q_next    = in_q;
    in_r_next    = in_r;
    in_row_next  = in_row;
    in_slot_next = in_slot;
    if (px) begin
      if (col_inc >= eff_w) begin
        in_col_next  = '0;
        in_q_next    = '0;
        in_r_next    = '0;
        in_row_next  = in_row + 1'b1;
        in_slot_next = (in_slot == SLW'(NROWS - 1)) ? '0 : in_slot + 1'b1;
      end else begin
        in_col_next = col_inc;
        if (in_r == BW'(KSIZE - 1)) begin
          in_r_next = '0;
          in_q_next = in_q + 1'b1;
        end else begin
          in_r_next = in_r + 1'b1;
        end
      end
    end
  end

  // an output goes once the bottom right pixel of its window has arrived
  always_comb begin
    cx_raw     = (CW + 1)'(out_col) + (CW + 1)'(R);
    cx         = (cx_raw > (CW + 1)'(wm1)) ? wm1 : cx_raw[CW-1:0];
    cy_raw     = ROW_W'(out_row) + ROW_W'(R);
    cy         = (cy_raw > hm1) ? hm1 : cy_raw;
    data_ready = (in_row_next >= eff_h) || (in_row_next > cy) ||
                 (in_row_next == cy && in_col_next > cx);
    issue.emit = accept && (in_word.mode == MODE_PIXEL || in_word.mode == MODE_FLUSH) &&
                 data_ready;
    ocol_inc   = out_col + 1'b1;
    wrap_col   = ocol_inc >= eff_w;
    orow_inc   = ROW_W'(out_row) + 1'b1;
    issue.last = issue.emit && wrap_col && orow_inc >= eff_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(RESET_WIDTH);
      frame_height <= CFG_W'(RESET_HEIGHT);
      in_col  <= '0;
      in_q    <= '0;
      in_r    <= '0;
      in_row  <= '0;
      in_slot <= '0;
      out_col <= '0;
      out_q   <= '0;
      out_r   <= '0;
      out_row <= '0;
      out_slot <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else begin
        frame_height <= cfg_data;
      end
      in_col  <= '0;
      in_q    <= '0;
      in_r    <= '0;
      in_row  <= '0;
      in_slot <= '0;
      out_col <= '0;
      out_q   <= '0;
      out_r   <= '0;
      out_row <= '0;
      out_slot <= '0;
    end else if (accept) begin
      in_col  <= in_col_next;
      in_q    <= in_q_next;
      in_r    <= in_r_next;
      in_row  <= in_row_next;
      in_slot <= in_slot_next;
      if (issue.last) begin
        in_col  <= '0;
        in_q    <= '0;
        in_r    <= '0;
        in_row  <= '0;
        in_slot <= '0;
        out_col <= '0;
        out_q   <= '0;
        out_r   <= '0;
        out_row <= '0;
        out_slot <= '0;
      end else if (issue.emit) begin
        if (wrap_col) begin
          out_col  <= '0;
          out_q    <= '0;
          out_r    <= '0;
          out_row  <= orow_inc[OROW_W-1:0];
          out_slot <= (out_slot == SLW'(NROWS - 1)) ? '0 : out_slot + 1'b1;
        end else begin
          out_col <= ocol_inc;
          if (out_r == BW'(KSIZE - 1)) begin
            out_r <= '0;
            out_q <= out_q + 1'b1;
          end else begin
            out_r <= out_r + 1'b1;
          end
        end
      end
    end
  end

  // per column bank: the one column of the unclamped window that lives there
  always_comb begin
    logic signed [SW-1:0] r_s, t;
    r_s = $signed(SW'(out_r));
    for (int b = 0; b < KSIZE; b++) begin
      t = SW'(b) - r_s;
      if (t > SW'(R)) begin
        raddr[b] = out_q - 1'b1;
      end else if (t < -SW'(R)) begin
        raddr[b] = out_q + 1'b1;
      end else begin
        raddr[b] = out_q;
      end
    end
  end

  // clamped column offsets to banks, clamped row offsets to slots
  always_comb begin
    logic signed [SW-1:0] r_s, oc_s, w_s, colv, off, s;
    logic signed [SW-1:0] sl_s, or_s, h_s, rowv, offy, s2;
    r_s  = $signed(SW'(out_r));
    oc_s = $signed(SW'(out_col));
    w_s  = $signed(SW'(wm1));
    sl_s = $signed(SW'(out_slot));
    or_s = $signed(SW'(out_row));
    h_s  = $signed(SW'(hm1));
    for (int l = 0; l < KSIZE; l++) begin
      colv = oc_s + SW'(l) - SW'(R);
      if (colv < 0) begin
        off = -oc_s;
      end else if (colv > w_s) begin
        off = w_s - oc_s;
      end else begin
        off = SW'(l) - SW'(R);
      end
      s = r_s + off;
      if (s < 0) begin
        s = s + SW'(KSIZE);
      end else if (s >= SW'(KSIZE)) begin
        s = s - SW'(KSIZE);
      end
      bank_c[l] = s[BW-1:0];
    end
    for (int m = 0; m < KSIZE; m++) begin
      rowv = or_s + SW'(m) - SW'(R);
      if (rowv < 0) begin
        offy = -or_s;
      end else if (rowv > h_s) begin
        offy = h_s - or_s;
      end else begin
        offy = SW'(m) - SW'(R);
      end
      s2 = sl_s + offy;
      if (s2 < 0) begin
        s2 = s2 + SW'(NROWS);
      end else if (s2 >= SW'(NROWS)) begin
        s2 = s2 - SW'(NROWS);
      end
      slot_c[m] = s2[SLW-1:0];
    end
  end

  assign all_pix = {in_word.blue_in, in_word.green_in, in_word.red_in};
  assign pix     = all_pix[CHANNELS-1:0];

  for (genvar gs = 0; gs < NROWS; gs++) begin : g_slot
    for (genvar gb = 0; gb < KSIZE; gb++) begin : g_bank
      cbwf_line_ram #(
        .DEPTH (DEPTH),
        .WIDTH (PIX_W)
      ) u_ram (
        .clk   (clk),
        .we    (px && in_slot == SLW'(gs) && in_r == BW'(gb)),
        .waddr (in_q),
        .wdata (pix),
        .re    (accept),
        .raddr (raddr[gb]),
        .rdata (rd[gs][gb])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bank_sel <= bank_c;
      slot_sel <= slot_c;
    end
    if (win_load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int m = 0; m < KSIZE; m++) begin
          for (int l = 0; l < KSIZE; l++) begin
            win[c][m][l] <= rd[slot_sel[m]][bank_sel[l]][8*c +: 8];
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/clamped_border_window_filter_core.sv =====
// clamped_border_window_filter_core: top level of the replicate-border window filter
// instantiates cbwf_window and one cbwf_lane per channel; uses cbwf_pkg
`timescale 1ns / 1ps

// usage
//   pix channel (pix_valid/pix_ready/pix_word): one word per handshake. mode 0 loads
//   one kernel coefficient, mode 1 delivers a pixel in raster order, mode 2 drains
//   one pending output at the end of a frame. a word gives at most one result.
//   res channel (res_valid/res_ready/res_word): filtered rgb, rounded and saturated
//   to 16 bit, with frame_last on the final pixel of a frame.
//   cfg port: cfg_we with cfg_index 0 (frame width) or 1 (frame height) writes
//   cfg_data at once and restarts the frame counters; write only while idle.
// throughput and pipeline
//   one word per clock sustained while res_ready stays high; every bank of line buffer
//   is read once and written once per clock, so gathering a window never holds the input back.
//   the accepting edge registers the bank read; the word then passes window gather,
//   multiply, row sums, total, round and saturate, and res_valid rises as it reaches the last.
// reset
//   rst clears the counters and sets 640 x 480; kernel and line buffers are
//   undefined until loaded.
// stall
//   a held result stalls only the stages behind it; pix_ready stays high while
//   any stage of the pipeline is empty.

module clamped_border_window_filter_core #(
  parameter int KSIZE     = 5,
  parameter int MAX_WIDTH = 1024,
  parameter int CHANNELS  = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  cbwf_pkg::in_word_t            pix_word,
  output logic                          res_valid,
  input  logic                          res_ready,
  output cbwf_pkg::out_word_t           res_word,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [cbwf_pkg::CFG_W-1:0]    cfg_data
);

  import cbwf_pkg::*;

  typedef enum logic {
    TOK_EMIT,
    TOK_COEF
  } tok_t;

  // stage 1 bank read, 2 window gather, 3 products, 4 row sums, 5 total, 6 result
  logic [6:1] vld;
  logic [6:1] rdy;
  logic [6:1] last;
  tok_t       kind1;

  logic               accept;
  issue_t             issue;
  lane_en_t           lane_en;
  logic               coef_go;
  logic [1:0]         coef_ch;
  logic [2:0]         coef_col, coef_row;
  logic signed [15:0] coef_val;

  logic [CHANNELS-1:0][KSIZE-1:0][KSIZE-1:0][7:0] win;
  logic signed [15:0] lane_res [3];

  // ready ripples back from the output register through empty stages
  always_comb begin
    rdy[6] = !vld[6] || res_ready;
    for (int i = 5; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign pix_ready = rdy[1];
  assign accept    = pix_valid && rdy[1];

  cbwf_window #(
    .KSIZE     (KSIZE),
    .MAX_WIDTH (MAX_WIDTH),
    .CHANNELS  (CHANNELS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_word   (pix_word),
    .win_load  (rdy[2]),
    .issue     (issue),
    .win       (win)
  );

  // control tokens: coefficient loads ride stage 1 so they land in order with outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= accept && (issue.emit || pix_word.mode == MODE_COEF);
      end
      if (rdy[2]) begin
        vld[2] <= vld[1] && kind1 == TOK_EMIT;
      end
      for (int i = 3; i <= 6; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      kind1    <= issue.emit ? TOK_EMIT : TOK_COEF;
      last[1]  <= issue.last;
      coef_ch  <= pix_word.coef_channel;
      coef_col <= pix_word.coef_col;
      coef_row <= pix_word.coef_row;
      coef_val <= pix_word.coef_value;
    end
    for (int i = 2; i <= 6; i++) begin
      if (rdy[i]) begin
        last[i] <= last[i-1];
      end
    end
  end

  // a load outside the kernel or the channel count is dropped
  assign coef_go = vld[1] && kind1 == TOK_COEF && rdy[2] &&
                   32'(coef_col) < KSIZE && 32'(coef_row) < KSIZE;

  assign lane_en = '{mul: rdy[3], rsum: rdy[4], tsum: rdy[5], fin: rdy[6]};

  for (genvar gc = 0; gc < 3; gc++) begin : g_lane
    if (gc < CHANNELS) begin : g_used
      coef_wr_t wr;
      assign wr = '{we: coef_go && coef_ch == 2'(gc), row: coef_row, col: coef_col,
                    value: coef_val};
      cbwf_lane #(
        .KSIZE (KSIZE)
      ) u_lane (
        .clk     (clk),
        .en      (lane_en),
        .coef_wr (wr),
        .win     (win[gc]),
        .result  (lane_res[gc])
      );
    end else begin : g_unused
      assign lane_res[gc] = '0;
    end
  end

  // merge the lanes into one result word
  assign res_valid           = vld[6];
  assign res_word.red_out    = lane_res[0];
  assign res_word.green_out  = lane_res[1];
  assign res_word.blue_out   = lane_res[2];
  assign res_word.frame_last = last[6];

  // input only stalls when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> (&vld) && !res_ready)
    else $error("input stalled with a free stage");

  // a kernel write never overtakes an output still waiting to multiply
  a_coef_order: assert property (@(posedge clk) disable iff (rst)
    coef_go |-> !vld[2] || rdy[3])
    else $error("coefficient written under a stalled output");

  // the end of a frame is only flagged on an emitted output
  a_last_emit: assert property (@(posedge clk) disable iff (rst)
    issue.last |-> issue.emit && accept)
    else $error("frame end without an output");

  // coefficient tokens never reach the arithmetic stages
  a_coef_drop: assert property (@(posedge clk) disable iff (rst)
    vld[1] && kind1 == TOK_COEF && rdy[2] |=> !vld[2])
    else $error("coefficient token entered the window stage");

endmodule

// ===== tb/sv/tb_clamped_border_window_filter_core.sv =====
// tb_clamped_border_window_filter_core: self-checking bench for the replicate-border window filter
// drives random frames through the pixel channel and checks every filtered result
// depends on cbwf_pkg and clamped_border_window_filter_core
`timescale 1ns / 1ps

module tb_clamped_border_window_filter_core;
  import cbwf_pkg::*;

  localparam int KS = 5;
  localparam int KR = 2;        // window radius
  localparam int NSLOT = KS + 1;
  localparam int MAXW = 1024;
  localparam int DRAIN_CYCLES = 12;

  // convolution predictor and store of filtered pixels still owed by the block
  class filter_scoreboard;
    out_word_t due_q[$];
    int fails;
    int checked;
    int reg_w, reg_h;
    logic signed [15:0] kern [3][KS][KS];
    logic [7:0] lines [NSLOT][MAXW][3];
    int in_col, in_row, out_col, out_row;

    function new();
      reg_w = RESET_WIDTH;
      reg_h = RESET_HEIGHT;
      fails = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void write_reg(logic idx, int val);
      if (idx == REG_FRAME_WIDTH) reg_w = val;
      else reg_h = val;
      restart();
    endfunction

    function int eff_w();
      return (reg_w < 1) ? 1 : (reg_w > MAXW) ? MAXW : reg_w;
    endfunction

    function int eff_h();
      return (reg_h < 1) ? 1 : (reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h;
    endfunction

    function int clip(int v, int hi);
      return (v < 0) ? 0 : (v > hi) ? hi : v;
    endfunction

    function logic signed [15:0] convolve(int c, int w, int h);
      longint acc;
      longint q;
      int y, x;
      acc = 0;
      for (int m = 0; m < KS; m++) begin
        y = clip(out_row + m - KR, h - 1);
        for (int l = 0; l < KS; l++) begin
          x = clip(out_col + l - KR, w - 1);
          acc += longint'(lines[y % NSLOT][x][c]) * longint'(kern[c][m][l]);
        end
      end
      q = (acc + ROUND_HALF) >>> FRAC_BITS;
      if (q > SAT_MAX) q = SAT_MAX;
      if (q < SAT_MIN) q = SAT_MIN;
      return q[15:0];
    endfunction

    // one output if every pixel of its window is in
    function void try_emit(int w, int h);
      out_word_t o;
      int cx, cy;
      if (in_row < h) begin
        cx = (out_col + KR > w - 1) ? w - 1 : out_col + KR;
        cy = (out_row + KR > h - 1) ? h - 1 : out_row + KR;
        if (in_row * w + in_col <= cy * w + cx) return;
      end
      o.red_out = convolve(0, w, h);
      o.green_out = convolve(1, w, h);
      o.blue_out = convolve(2, w, h);
      o.frame_last = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= h) begin
          o.frame_last = 1'b1;
          restart();
        end
      end
      due_q.push_back(o);
    endfunction

    function void note_input(in_word_t wd);
      int w, h;
      w = eff_w();
      h = eff_h();
      case (wd.mode)
        MODE_COEF: begin
          if (wd.coef_channel < 3 && wd.coef_col < KS && wd.coef_row < KS)
            kern[wd.coef_channel][wd.coef_row][wd.coef_col] = wd.coef_value;
        end
        MODE_PIXEL: begin
          if (in_row < h && in_col < w) begin
            lines[in_row % NSLOT][in_col][0] = wd.red_in;
            lines[in_row % NSLOT][in_col][1] = wd.green_in;
            lines[in_row % NSLOT][in_col][2] = wd.blue_in;
            in_col++;
            if (in_col >= w) begin
              in_col = 0;
              in_row++;
            end
          end
          try_emit(w, h);
        end
        MODE_FLUSH: try_emit(w, h);
        default: ;
      endcase
    endfunction

    function void check(out_word_t got);
      out_word_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fails++;
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.red_out !== want.red_out) begin
        $display("%0t: red_out expected %0d actual %0d", $time, want.red_out, got.red_out);
        fails++;
      end
      if (got.green_out !== want.green_out) begin
        $display("%0t: green_out expected %0d actual %0d", $time, want.green_out,
                 got.green_out);
        fails++;
      end
      if (got.blue_out !== want.blue_out) begin
        $display("%0t: blue_out expected %0d actual %0d", $time, want.blue_out,
                 got.blue_out);
        fails++;
      end
      if (got.frame_last !== want.frame_last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, want.frame_last,
                 got.frame_last);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_ready;
  in_word_t pix_word;
  logic res_valid;
  logic res_ready;
  out_word_t res_word;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  filter_scoreboard sb;
  int tx_idle;
  int rx_idle;
  int words_sent;
  int frames_run;

  clamped_border_window_filter_core DUT (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready), .pix_word(pix_word),
    .res_valid(res_valid), .res_ready(res_ready), .res_word(res_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check on handshake, stall at random
  initial begin
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) sb.check(res_word);
      res_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send(in_word_t wd);
    while ($urandom_range(99) < tx_idle) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_word <= wd;
    do @(posedge clk); while (!pix_ready);
    sb.note_input(wd);
    words_sent++;
  endtask

  // hold off until every owed result is back, then let the pipeline empty
  task automatic drain();
    pix_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w[CFG_W-1:0];
    @(posedge clk);
    sb.write_reg(REG_FRAME_WIDTH, w);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h[CFG_W-1:0];
    @(posedge clk);
    sb.write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  function automatic in_word_t coef_word(int ch, int l, int m, logic [15:0] v);
    in_word_t wd;
    wd = '0;
    wd.mode = MODE_COEF;
    wd.coef_channel = ch[1:0];
    wd.coef_col = l[2:0];
    wd.coef_row = m[2:0];
    wd.coef_value = v;
    return wd;
  endfunction

  function automatic logic [15:0] rand_coef();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'($urandom_range(16'hffff));
    if (r == 1) return ($urandom_range(1) == 1) ? 16'h7fff : 16'h8000;
    return 16'($signed($urandom_range(6000)) - 3000);
  endfunction

  function automatic in_word_t pixel_word(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_word_t wd;
    wd = '0;
    wd.mode = MODE_PIXEL;
    wd.red_in = r;
    wd.green_in = g;
    wd.blue_in = b;
    wd.coef_value = 16'($urandom_range(16'hffff));  // ignored on pixels
    return wd;
  endfunction

  function automatic in_word_t rand_pixel();
    return pixel_word(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
  endfunction

  function automatic in_word_t flush_word();
    in_word_t wd;
    wd = '0;
    wd.mode = MODE_FLUSH;
    return wd;
  endfunction

  // odd words mixed into a frame
  function automatic in_word_t noise_word();
    in_word_t wd;
    case ($urandom_range(3))
      0: begin
        wd = rand_pixel();
        wd.mode = 2'd3;                 // unused mode, ignored
      end
      1: wd = coef_word($urandom_range(3), $urandom_range(7), $urandom_range(7),
                        rand_coef());   // often out of range, ignored
      2: wd = flush_word();
      default: wd = coef_word($urandom_range(2), $urandom_range(4), $urandom_range(4),
                              rand_coef());
    endcase
    return wd;
  endfunction

  task automatic load_kernels(int kind);
    logic [15:0] v;
    for (int ch = 0; ch < 3; ch++)
      for (int m = 0; m < KS; m++)
        for (int l = 0; l < KS; l++) begin
          case (kind)
            0: v = (m == KR && l == KR) ? 16'h4000 : 16'h0000;   // pass-through
            1: v = (ch == 0) ? 16'h7fff : (ch == 1) ? 16'h8000 : 16'h0666;
            default: v = rand_coef();
          endcase
          send(coef_word(ch, l, m, v));
        end
  endtask

  // one frame: pixels with some noise, sometimes cut short; a full frame then has its tail drained
  task automatic run_frame(int w, int h, bit cut);
    int npix, sent;
    npix = sb.eff_w() * sb.eff_h();
    if (cut) npix = $urandom_range(npix);
    sent = 0;
    while (sent < npix) begin
      if ($urandom_range(99) < 6) send(noise_word());
      else begin
        send(rand_pixel());
        sent++;
      end
    end
    frames_run++;
    if (cut) return;
    while (sb.in_row >= sb.eff_h()) begin
      if ($urandom_range(1)) send(flush_word());
      else send(rand_pixel());          // dropped, drains like a flush
    end
    if ($urandom_range(2) == 0) send(flush_word());   // nothing left to drain
  endtask

  task automatic random_frames(int budget);
    int w, h, start;
    start = words_sent;
    while (words_sent - start < budget) begin
      if ($urandom_range(99) < 90) begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 12);
      end
      set_frame(w, h);
      if ($urandom_range(3) == 0) load_kernels(2);
      run_frame(w, h, $urandom_range(9) == 0);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    pix_valid = 1'b0;
    pix_word = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    tx_idle = 16;
    rx_idle = 46;
    words_sent = 0;
    frames_run = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: whole kernel loaded before any pixel, then edge cases
    load_kernels(1);
    set_frame(3, 2);
    send(pixel_word(8'h00, 8'hff, 8'h00));
    send(pixel_word(8'hff, 8'h00, 8'hff));
    send(flush_word());                  // nothing ready yet
    send(noise_word());
    send(coef_word(3, 1, 1, 16'h1234));  // channel out of range
    send(coef_word(0, 5, 7, 16'h1234));  // offsets out of range
    for (int i = 0; i < 4; i++) send(pixel_word(8'hff, 8'hff, 8'hff));
    send(rand_pixel());                  // past the end, drains
    while (sb.in_row >= sb.eff_h()) send(flush_word());
    load_kernels(0);
    set_frame(0, 0);                     // clamps to one pixel
    run_frame(0, 0, 1'b0);
    set_frame(2047, 1);                  // widest line
    run_frame(2047, 1, 1'b0);
    set_frame(1, 2047);                  // tallest column, top rows only
    for (int i = 0; i < 30; i++) send(rand_pixel());
    set_frame(5, 4);
    run_frame(5, 4, 1'b1);               // abandoned by the next write
    load_kernels(2);

    random_frames(180);
    tx_idle = 46;
    rx_idle = 16;
    random_frames(180);
    tx_idle = 0;
    rx_idle = 0;
    random_frames(180);

    drain();
    $display("covered %0d words in %0d frames, %0d filtered pixels checked", words_sent,
             frames_run, sb.checked);
    $display("frame sizes from one pixel to full width and height, all modes and stalls");
    if (sb.fails == 0 && sb.due_q.size() == 0) begin
      $display("tb_clamped_border_window_filter_core: PASS");
    end else begin
      $display("tb_clamped_border_window_filter_core: FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout with %0d results owed", sb.due_q.size());
    $display("tb_clamped_border_window_filter_core: FAIL");
    $finish;
  end

endmodule
